// ===== hw/rtl/sdh_pkg.sv =====
// shared types, constants and modular helpers for the substring double hash block
// no dependencies
package sdh_pkg;

	localparam int unsigned MAX_LEN = 4096;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned LEN_W   = 13;
	localparam int unsigned HASH_W  = 30;

	localparam logic [HASH_W-1:0] MOD_A = 30'd1000000007;
	localparam logic [HASH_W-1:0] MOD_B = 30'd1000000009;
	localparam logic [HASH_W-1:0] HASH_BASE = 30'd29;
	localparam logic [6:0] CODE_BIAS = 7'd96;

	// reciprocals floor(2^60 / m) for the reduction step
	localparam logic [HASH_W:0] MU_A = 31'(64'h1000_0000_0000_0000 / 64'd1000000007);
	localparam logic [HASH_W:0] MU_B = 31'(64'h1000_0000_0000_0000 / 64'd1000000009);

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_FWD  = 2'd1;
	localparam logic [1:0] CMD_REV  = 2'd2;

	// 29^(m-2) mod m, evaluated at elaboration
	function automatic logic [HASH_W-1:0] inv_base(input logic sel);
		longint unsigned r;
		longint unsigned a;
		longint unsigned e;
		r = 1;
		a = 29;
		e = sel ? (64'd1000000009 - 64'd2) : (64'd1000000007 - 64'd2);
		for (int i = 0; i < 32; i++) begin
			if (e[i]) begin
				r = sel ? (r * a) % 64'd1000000009 : (r * a) % 64'd1000000007;
			end
			a = sel ? (a * a) % 64'd1000000009 : (a * a) % 64'd1000000007;
		end
		return r[HASH_W-1:0];
	endfunction

	localparam logic [HASH_W-1:0] INV_A = inv_base(1'b0);
	localparam logic [HASH_W-1:0] INV_B = inv_base(1'b1);

	typedef struct packed {
		logic [HASH_W-1:0] p1;
		logic [HASH_W-1:0] p2;
		logic [HASH_W-1:0] q1;
		logic [HASH_W-1:0] q2;
	} quad_t;

	typedef struct packed {
		logic             is_load;
		logic             rev;
		logic             err;
		logic [IDX_W-1:0] idx_a;
		logic [IDX_W-1:0] idx_b;
		logic [6:0]       byte_val;
	} item_t;

	function automatic logic [HASH_W-1:0] mod_of(input logic sel);
		return sel ? MOD_B : MOD_A;
	endfunction

	function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] a,
		input logic [HASH_W-1:0] b, input logic sel);
		logic [HASH_W:0] s;
		logic [HASH_W:0] m;
		m = {1'b0, mod_of(sel)};
		s = {1'b0, a} + {1'b0, b};
		if (s >= m) begin
			s = s - m;
		end
		return s[HASH_W-1:0];
	endfunction

	function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] a,
		input logic [HASH_W-1:0] b, input logic sel);
		logic [HASH_W:0] s;
		s = {1'b0, a} + {1'b0, mod_of(sel)} - {1'b0, b};
		if (a >= b) begin
			s = {1'b0, a} - {1'b0, b};
		end
		return s[HASH_W-1:0];
	endfunction

	// letter code byte - 96, taken modulo m
	function automatic logic [HASH_W-1:0] code_of(input logic [6:0] b, input logic sel);
		logic [HASH_W-1:0] r;
		r = {23'd0, b - CODE_BIAS};
		if (b < CODE_BIAS) begin
			r = mod_of(sel) - {23'd0, CODE_BIAS - b};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/sdh_modmul.sv =====
// pipelined modular multiplier: 30x30 product, then reciprocal reduction
// depends on sdh_pkg
module sdh_modmul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      msel,
	input  logic [sdh_pkg::HASH_W-1:0] a,
	input  logic [sdh_pkg::HASH_W-1:0] b,
	output logic                      done,
	output logic [sdh_pkg::HASH_W-1:0] result
);
	import sdh_pkg::*;

	logic [2*HASH_W-1:0] prod_s1;
	logic [2*HASH_W+1:0] est_s2, est;
	logic [31:0]         low_s2, low_s3, qm_s3;
	logic                vld_s1, vld_s2, vld_s3, done_q;
	logic [HASH_W-1:0]   r_q;
	logic [HASH_W:0]     mu, quot;
	logic [2*HASH_W:0]   qm_full;
	logic [31:0]         m32, rem0, rem1, rem2;

	always_comb begin
		mu = msel ? MU_B : MU_A;
		m32 = {2'b00, mod_of(msel)};
		// quotient estimate from the top 31 product bits
		est = {31'd0, prod_s1[2*HASH_W-1:HASH_W-1]} * {31'd0, mu};
		quot = est_s2[2*HASH_W+1:HASH_W+1];
		qm_full = {30'd0, quot} * {31'd0, mod_of(msel)};
		// estimate is short by at most two, so the low 32 bits hold the remainder
		rem0 = low_s3 - qm_s3;
		rem1 = (rem0 >= m32) ? rem0 - m32 : rem0;
		rem2 = (rem1 >= m32) ? rem1 - m32 : rem1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= {{HASH_W{1'b0}}, a} * {{HASH_W{1'b0}}, b};
		end
		if (vld_s1) begin
			est_s2 <= est;
			low_s2 <= prod_s1[31:0];
		end
		if (vld_s2) begin
			qm_s3 <= qm_full[31:0];
			low_s3 <= low_s2;
		end
		if (vld_s3) begin
			r_q <= rem2[HASH_W-1:0];
		end
	end

	assign done = done_q;
	assign result = r_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !(vld_s1 || vld_s2 || vld_s3)) else $error("multiplier restarted while busy");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(vld_s1 || vld_s2 || vld_s3)) else $error("done while still busy");
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (r_q < mod_of(msel))) else $error("product not reduced");
`endif

endmodule

// ===== hw/rtl/sdh_queue.sv =====
// two-entry queue between the front and back parts
// depends on sdh_pkg
module sdh_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sdh_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output sdh_pkg::item_t head
);
	import sdh_pkg::*;

	item_t       mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	assign full = cnt_q[1];
	assign nonempty = cnt_q != 2'd0;
	assign head = mem_q[rd_q];

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

// ===== hw/rtl/sdh_front.sv =====
// front part: accepts commands, tracks string length, range-checks queries
// depends on sdh_pkg
module sdh_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                cmd,
	input  logic                      new_string,
	input  logic [6:0]                char_byte,
	input  logic [sdh_pkg::IDX_W-1:0] left_index,
	input  logic [sdh_pkg::IDX_W-1:0] right_index,
	input  logic                      back_ready,
	input  logic                      q_full,
	output logic                      push,
	output sdh_pkg::item_t            push_item
);
	import sdh_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic             acc, is_load, is_query, store_full;
	logic [IDX_W-1:0] pos;

	always_comb begin
		in_stall = !back_ready || q_full;
		acc = in_valid && !in_stall;
		is_load = cmd == CMD_LOAD;
		is_query = (cmd == CMD_FWD) || (cmd == CMD_REV);
		store_full = !new_string && (len_q == LEN_W'(MAX_LEN));
		pos = new_string ? '0 : len_q[IDX_W-1:0];
		push = acc && ((is_load && !store_full) || is_query);
		push_item.is_load = is_load;
		push_item.rev = cmd == CMD_REV;
		push_item.err = (left_index > right_index) || ({1'b0, right_index} >= len_q);
		push_item.idx_a = is_load ? pos : left_index;
		push_item.idx_b = right_index;
		push_item.byte_val = char_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (acc && is_load && !store_full) begin
			len_q <= {1'b0, pos} + 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LEN)) else $error("length beyond store");
	a_no_push_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> !push) else $error("push while stalled");
	a_fresh_len: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_load && new_string |=> len_q == LEN_W'(1))
		else $error("new string length wrong");
`endif

endmodule

// ===== hw/rtl/sdh_back.sv =====
// back part: table fill after reset, prefix sum updates and hash queries
// depends on sdh_pkg and sdh_modmul
module sdh_back (
	input  logic                       clk,
	input  logic                       arst_n,
	output logic                       ready,
	input  logic                       q_nonempty,
	input  sdh_pkg::item_t             head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [sdh_pkg::HASH_W-1:0] hash_first,
	output logic [sdh_pkg::HASH_W-1:0] hash_second,
	output logic                       status
);
	import sdh_pkg::*;

	localparam logic [3:0] ST_FILL      = 4'd0;
	localparam logic [3:0] ST_FILL_WAIT = 4'd1;
	localparam logic [3:0] ST_IDLE      = 4'd2;
	localparam logic [3:0] ST_LD_MUL    = 4'd3;
	localparam logic [3:0] ST_LD_WAIT   = 4'd4;
	localparam logic [3:0] ST_Q_RD2     = 4'd5;
	localparam logic [3:0] ST_Q_RD3     = 4'd6;
	localparam logic [3:0] ST_Q_WAIT    = 4'd7;
	localparam logic [3:0] ST_OUT       = 4'd8;

	quad_t tab_mem [MAX_LEN];
	quad_t sum_mem [MAX_LEN];

	logic [3:0]        st_q;
	logic [IDX_W-1:0]  fill_idx_q;
	logic [HASH_W-1:0] pw1_q, pw2_q, iv1_q, iv2_q;
	logic              rev_q;
	logic [IDX_W-1:0]  l_q;
	logic [HASH_W-1:0] code1_q, code2_q, res1_q, res2_q;
	logic              err_q;
	quad_t             tab_rd_q, sum_rd_q, prev_q, hi_q, tv_q, sum_wdata, lo;
	logic [IDX_W-1:0]  tab_raddr, sum_raddr;
	logic              sum_we, tab_we, mul_start, slot_free;
	logic              out_valid_q, status_q;
	logic [HASH_W-1:0] hf_q, hs_q, v1, v2;
	logic [HASH_W-1:0] mul_a [4];
	logic [HASH_W-1:0] mul_b [4];
	logic [HASH_W-1:0] mul_r [4];
	logic [3:0]        mul_done;

	for (genvar i = 0; i < 4; i++) begin : g_mul
		sdh_modmul u_mul (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (mul_start),
			.msel   (1'(i % 2)),
			.a      (mul_a[i]),
			.b      (mul_b[i]),
			.done   (mul_done[i]),
			.result (mul_r[i])
		);
	end

	always_comb begin
		ready = st_q != ST_FILL && st_q != ST_FILL_WAIT;
		slot_free = !out_valid_q || !out_stall;
		pop = st_q == ST_IDLE && q_nonempty;
		tab_we = st_q == ST_FILL;
		lo = (l_q == '0) ? '0 : sum_rd_q;
		v1 = rev_q ? sub_mod(hi_q.q1, lo.q1, 1'b0) : sub_mod(hi_q.p1, lo.p1, 1'b0);
		v2 = rev_q ? sub_mod(hi_q.q2, lo.q2, 1'b1) : sub_mod(hi_q.p2, lo.p2, 1'b1);
		sum_wdata.p1 = add_mod(prev_q.p1, mul_r[0], 1'b0);
		sum_wdata.p2 = add_mod(prev_q.p2, mul_r[1], 1'b1);
		sum_wdata.q1 = add_mod(prev_q.q1, mul_r[2], 1'b0);
		sum_wdata.q2 = add_mod(prev_q.q2, mul_r[3], 1'b1);
		sum_we = st_q == ST_LD_WAIT && mul_done[0];
		// read addresses: pop issues the first read, second state the low bound
		tab_raddr = head.is_load ? head.idx_a : (head.rev ? head.idx_b : head.idx_a);
		sum_raddr = head.is_load ? head.idx_a - 1'b1 : head.idx_b;
		if (st_q == ST_Q_RD2) sum_raddr = l_q - 1'b1;
		mul_start = 1'b0;
		mul_a[0] = pw1_q;   mul_b[0] = HASH_BASE;
		mul_a[1] = pw2_q;   mul_b[1] = HASH_BASE;
		mul_a[2] = iv1_q;   mul_b[2] = INV_A;
		mul_a[3] = iv2_q;   mul_b[3] = INV_B;
		unique case (st_q)
			ST_FILL: begin
				mul_start = fill_idx_q != IDX_W'(MAX_LEN - 1);
			end
			ST_LD_MUL: begin
				mul_start = 1'b1;
				mul_a[0] = code1_q; mul_b[0] = tab_rd_q.p1;
				mul_a[1] = code2_q; mul_b[1] = tab_rd_q.p2;
				mul_a[2] = code1_q; mul_b[2] = tab_rd_q.q1;
				mul_a[3] = code2_q; mul_b[3] = tab_rd_q.q2;
			end
			ST_Q_RD3: begin
				mul_start = 1'b1;
				mul_a[0] = v1; mul_b[0] = rev_q ? tv_q.p1 : tv_q.q1;
				mul_a[1] = v2; mul_b[1] = rev_q ? tv_q.p2 : tv_q.q2;
				mul_a[2] = v1; mul_b[2] = mul_b[0];
				mul_a[3] = v2; mul_b[3] = mul_b[1];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		tab_rd_q <= tab_mem[tab_raddr];
		sum_rd_q <= sum_mem[sum_raddr];
		if (tab_we) tab_mem[fill_idx_q] <= '{p1: pw1_q, p2: pw2_q, q1: iv1_q, q2: iv2_q};
		if (sum_we) sum_mem[l_q] <= sum_wdata;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rev_q <= head.rev;
			l_q <= head.idx_a;
			code1_q <= code_of(head.byte_val, 1'b0);
			code2_q <= code_of(head.byte_val, 1'b1);
		end
		if (st_q == ST_LD_MUL) prev_q <= (l_q == '0) ? '0 : sum_rd_q;
		if (st_q == ST_Q_RD2) begin
			hi_q <= sum_rd_q;
			tv_q <= tab_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_FILL;
			fill_idx_q <= '0;
			pw1_q <= 30'd1;
			pw2_q <= 30'd1;
			iv1_q <= 30'd1;
			iv2_q <= 30'd1;
			err_q <= 1'b0;
			res1_q <= '0;
			res2_q <= '0;
			out_valid_q <= 1'b0;
			status_q <= 1'b0;
			hf_q <= '0;
			hs_q <= '0;
		end else begin
			if (st_q == ST_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_FILL: begin
					st_q <= (fill_idx_q == IDX_W'(MAX_LEN - 1)) ? ST_IDLE : ST_FILL_WAIT;
				end
				ST_FILL_WAIT: begin
					if (mul_done[0]) begin
						pw1_q <= mul_r[0];
						pw2_q <= mul_r[1];
						iv1_q <= mul_r[2];
						iv2_q <= mul_r[3];
						fill_idx_q <= fill_idx_q + 1'b1;
						st_q <= ST_FILL;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						if (head.is_load) begin
							st_q <= ST_LD_MUL;
						end else if (head.err) begin
							err_q <= 1'b1;
							res1_q <= '0;
							res2_q <= '0;
							st_q <= ST_OUT;
						end else begin
							st_q <= ST_Q_RD2;
						end
					end
				end
				ST_LD_MUL: st_q <= ST_LD_WAIT;
				ST_LD_WAIT: begin
					if (mul_done[0]) st_q <= ST_IDLE;
				end
				ST_Q_RD2: st_q <= ST_Q_RD3;
				ST_Q_RD3: st_q <= ST_Q_WAIT;
				ST_Q_WAIT: begin
					if (mul_done[0]) begin
						err_q <= 1'b0;
						res1_q <= mul_r[0];
						res2_q <= mul_r[1];
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (slot_free) begin
						hf_q <= res1_q;
						hs_q <= res2_q;
						status_q <= err_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign hash_first = hf_q;
	assign hash_second = hs_q;
	assign status = status_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> hf_q == '0 && hs_q == '0)
		else $error("error result with nonzero hash");
	a_no_pop_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |-> !pop) else $error("item taken during table fill");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FILL && fill_idx_q != IDX_W'(MAX_LEN - 1) |=> st_q == ST_FILL_WAIT)
		else $error("fill sequence broken");
	a_hash_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> hf_q < MOD_A && hs_q < MOD_B) else $error("hash not reduced");
`endif

endmodule

// ===== hw/rtl/substring_double_hash_query.sv =====
// substring hash block: the back part takes a load through LD_MUL and LD_WAIT, a query
// through Q_RD2, Q_RD3, Q_WAIT and OUT, and a range error straight to OUT; a result
// waits in OUT while out_stall holds the output register.
// four pipelined modular multipliers, items worked one at a time
// after reset the power tables are filled, 4096 entries, with in_stall high
// reset clears the string length; the prefix sum store is not cleared
module substring_double_hash_query (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                cmd,
	input  logic                      new_string,
	input  logic [6:0]                char_byte,
	input  logic [sdh_pkg::IDX_W-1:0] left_index,
	input  logic [sdh_pkg::IDX_W-1:0] right_index,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [sdh_pkg::HASH_W-1:0] hash_first,
	output logic [sdh_pkg::HASH_W-1:0] hash_second,
	output logic                      status
);
	import sdh_pkg::*;

	logic  back_ready, q_full, push, pop, q_nonempty;
	item_t push_item, head;

	sdh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.new_string  (new_string),
		.char_byte   (char_byte),
		.left_index  (left_index),
		.right_index (right_index),
		.back_ready  (back_ready),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	sdh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_nonempty),
		.head      (head)
	);

	sdh_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ready       (back_ready),
		.q_nonempty  (q_nonempty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hash_first  (hash_first),
		.hash_second (hash_second),
		.status      (status)
	);

endmodule
